[rtl/median_of_recent_block_times_defines.svh]
// assertion macros for the block timestamp median block
// used by the top level only, no other dependencies
`ifndef MEDIAN_OF_RECENT_BLOCK_TIMES_DEFINES_SVH
`define MEDIAN_OF_RECENT_BLOCK_TIMES_DEFINES_SVH

// check in the same cycle
`define MRBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check in the next cycle
`define MRBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mrbt_pkg.sv]
// shared constants and controller command type for the timestamp median block
// no dependencies
package mrbt_pkg;

  localparam int WINDOW_DEF = 11;
  localparam int TIME_W     = 32;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture input item
    logic remove;    // restart window or drop oldest entry
    logic insert;    // place new timestamp in sorted order
    logic load_out;  // register the median
  } mrbt_cmd_t;

endpackage

[rtl/mrbt_ctrl.sv]
// sequencer for the timestamp median block: remove, insert, emit per item
// depends on mrbt_pkg
module mrbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mrbt_pkg::mrbt_cmd_t cmd
);
  import mrbt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_REMOVE;
        end
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        // wait here until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/mrbt_dp.sv]
// datapath: age-ordered shift line, sorted copy of the window, median register
// depends on mrbt_pkg
module mrbt_dp #(
  parameter int WINDOW = mrbt_pkg::WINDOW_DEF,
  parameter int CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mrbt_pkg::mrbt_cmd_t         cmd,
  input  logic [mrbt_pkg::TIME_W-1:0] block_time,
  input  logic                        chain_start,
  output logic [mrbt_pkg::TIME_W-1:0] median_time,
  output logic [CNT_W-1:0]            held_cnt
);
  import mrbt_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [TIME_W-1:0] age_r    [WINDOW];
  logic [TIME_W-1:0] age_nxt  [WINDOW];
  logic [TIME_W-1:0] sort_r   [WINDOW];
  logic [TIME_W-1:0] sort_nxt [WINDOW];
  logic [TIME_W-1:0] time_r;
  logic              start_r;
  logic [TIME_W-1:0] med_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WINDOW-1:0] hit;
  logic [WINDOW-1:0] seen;
  logic [WINDOW-1:0] le;
  logic [IDX_W-1:0]  med_idx;
  logic              full;

  assign full        = (cnt_r == CNT_W'(WINDOW));
  assign med_idx     = IDX_W'(cnt_r >> 1);
  assign median_time = med_r;
  assign held_cnt    = cnt_r;

  // oldest value matches and prefix of matches, for removal; entries not above the new value, for insertion
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      hit[i] = (sort_r[i] == age_r[WINDOW-1]);
    end
    for (int i = 0; i < WINDOW; i++) begin
      seen[i] = |(hit & ({WINDOW{1'b1}} >> (WINDOW - 1 - i)));
    end
    for (int i = 0; i < WINDOW; i++) begin
      le[i] = (CNT_W'(i) < cnt_r) && (sort_r[i] <= time_r);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < WINDOW; i++) begin
      sort_nxt[i] = sort_r[i];
      age_nxt[i]  = age_r[i];
    end
    if (cmd.remove) begin
      if (start_r) begin
        cnt_nxt = '0;
      end else if (full) begin
        // close the gap left by the first copy of the oldest value
        for (int i = 0; i < WINDOW - 1; i++) begin
          if (seen[i]) begin
            sort_nxt[i] = sort_r[i+1];
          end
        end
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end else if (cmd.insert) begin
      sort_nxt[0] = le[0] ? sort_r[0] : time_r;
      for (int i = 1; i < WINDOW; i++) begin
        if (le[i]) begin
          sort_nxt[i] = sort_r[i];
        end else if (le[i-1]) begin
          sort_nxt[i] = time_r;
        end else begin
          sort_nxt[i] = sort_r[i-1];
        end
      end
      age_nxt[0] = time_r;
      for (int i = 1; i < WINDOW; i++) begin
        age_nxt[i] = age_r[i-1];
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW; i++) begin
      sort_r[i] <= sort_nxt[i];
      age_r[i]  <= age_nxt[i];
    end
    if (cmd.load_in) begin
      time_r  <= block_time;
      start_r <= chain_start;
    end
    if (cmd.load_out) begin
      med_r <= sort_r[med_idx];
    end
  end

endmodule

[rtl/median_of_recent_block_times.sv]
// median of the last WINDOW block timestamps, upper median for even counts
// after an input transfer the controller steps through its remove, insert and emit states;
// out_tvalid is registered once emit finds the output free, and no new item is taken until
// emit is done; in_tready is high only while the controller is idle
// reset (rst_n low, synchronous) empties the window and drops any pending result
module median_of_recent_block_times #(
  parameter int WINDOW = mrbt_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mrbt_pkg::TIME_W-1:0] in_tdata,   // block_time
  input  logic                        in_tuser,   // chain_start
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mrbt_pkg::TIME_W-1:0] out_tdata   // median_time
);
  import mrbt_pkg::*;
  `include "median_of_recent_block_times_defines.svh"

  localparam int CNT_W = $clog2(WINDOW + 1);

  mrbt_cmd_t        cmd;
  logic [CNT_W-1:0] held_cnt;

  mrbt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mrbt_dp #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .block_time  (in_tdata),
    .chain_start (in_tuser),
    .median_time (out_tdata),
    .held_cnt    (held_cnt)
  );

  `MRBT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second transfer taken while busy")
  `MRBT_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, held_cnt <= CNT_W'(WINDOW), "held count beyond window")
  `MRBT_ASSERT_NOW(a_result_nonempty, clk, rst_n, $rose(out_tvalid), held_cnt != '0, "result from empty window")
  `MRBT_ASSERT_NOW(a_single_cmd, clk, rst_n, 1'b1, $onehot0(cmd), "overlapping controller commands")

endmodule
